[rtl/zsn_pkg.sv]
// shared constants, types and controller states of the z-score normaliser
`timescale 1ns / 1ps
package zsn_pkg;

    localparam int DEF_MAX_SAMPLES = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    // z-score is signed q6.10
    localparam int ZW          = 16;
    localparam int KW          = 16;
    localparam int FRAC_SHIFT  = 20;

    localparam logic [KW-1:0] Z_POS_LIMIT = 16'd32767;
    localparam logic [KW-1:0] Z_NEG_LIMIT = 16'd32768;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_READ,
        ST_DIFF,
        ST_SQ,
        ST_SQSUM,
        ST_ACC,
        ST_RHS,
        ST_TRIAL,
        ST_DECIDE,
        ST_OUT
    } zsn_state_t;

    typedef struct packed {
        logic store;
        logic w_clr;
        logic idx_clr;
        logic idx_inc;
        logic rd;
        logic diff;
        logic sq;
        logic sqsum;
        logic acc;
        logic rhs;
        logic trial;
        logic decide;
        logic run_clr;
    } zsn_cmd_t;

    typedef struct packed {
        logic last_idx;
        logic skip;
        logic bit_zero;
    } zsn_status_t;

endpackage

[rtl/zsn_if.sv]
// sample and result channel interfaces
`timescale 1ns / 1ps
interface zsn_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          final_sample;

    modport source (output valid, sample, final_sample, input ready);
    modport sink   (input valid, sample, final_sample, output ready);
endinterface

interface zsn_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] zscore;
    logic               flat_column;
    logic               saturated;
    logic               final_result;

    modport source (output valid, zscore, flat_column, saturated, final_result, input ready);
    modport sink   (input valid, zscore, flat_column, saturated, final_result, output ready);
endinterface

[rtl/zscore_normalizer_core.sv]
// Z-score normaliser: takes one column of signed samples, one beat per cycle, the last beat
// marked by final_sample, and then returns one beat per stored sample, in arrival order,
// holding (x - mean) / std in signed Q6.10 (population deviation, truncated toward zero,
// saturated), or zero with flat_column set when the deviation is zero. Samples beyond
// MAX_SAMPLES are dropped. After the last sample, a statistics pass reads, differences,
// squares and accumulates each stored sample; then each result is found by fetch and
// squaring and a 16-bit shift-and-add search for the quotient of the root, and its
// beat waits for ready; a flat column or a sample equal to the mean skips the search.
// No new sample is taken until the last result leaves.
`timescale 1ns / 1ps
module zscore_normalizer_core #(
    parameter int MAX_SAMPLES = zsn_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = zsn_pkg::DEF_SAMPLE_BITS
) (
    input logic      clk,
    input logic      rst_n,
    zsn_in_if.sink   samples,
    zsn_out_if.source results
);
    import zsn_pkg::*;

    zsn_cmd_t    cmd;
    zsn_status_t status;

    zsn_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (samples.valid),
        .final_sample (samples.final_sample),
        .in_ready     (samples.ready),
        .out_valid    (results.valid),
        .out_ready    (results.ready),
        .cmd          (cmd),
        .status       (status)
    );

    zsn_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .sample      (samples.sample),
        .zscore      (results.zscore),
        .flat_column (results.flat_column),
        .saturated   (results.saturated)
    );

    assign results.final_result = status.last_idx;

endmodule

[rtl/zsn_datapath.sv]
// sample store, statistics and bit-serial z-score search
`timescale 1ns / 1ps
module zsn_datapath #(
    parameter int MAX_SAMPLES = zsn_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = zsn_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  zsn_pkg::zsn_cmd_t             cmd,
    output zsn_pkg::zsn_status_t          status,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [zsn_pkg::ZW-1:0] zscore,
    output logic                          flat_column,
    output logic                          saturated
);
    import zsn_pkg::*;

    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int SW   = SAMPLE_BITS + CW;
    localparam int DW   = SW + 1;
    localparam int MW   = SW;
    localparam int H    = (MW + 1) / 2;
    localparam int L    = MW - H;
    localparam int SQW  = 2 * MW;
    localparam int WW   = SQW + CW;
    localparam int RW   = SQW + CW + FRAC_SHIFT;
    localparam int KWW  = WW + KW;
    localparam int TW   = WW + 2 * KW;
    localparam int BW   = $clog2(KW);

    logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];

    logic [CW-1:0]                 count_reg;
    logic signed [SW-1:0]          sum_reg;
    logic [AW-1:0]                 idx_reg;
    logic signed [SAMPLE_BITS-1:0] rd_reg;
    logic signed [DW-1:0]          d_reg;
    logic [2*L-1:0]                pp_hh_reg;
    logic [H+L-1:0]                pp_hl_reg;
    logic [2*H-1:0]                pp_ll_reg;
    logic [SQW-1:0]                m2_reg;
    logic [WW-1:0]                 w_reg;
    logic [RW-1:0]                 r_reg;
    logic [TW-1:0]                 p_reg;
    logic [TW-1:0]                 trial_reg;
    logic [KWW-1:0]                wk_reg;
    logic [KW-1:0]                 k_reg;
    logic [BW-1:0]                 bit_reg;

    logic [DW-1:0] mag_full;
    logic [MW-1:0] mag;
    logic          neg;
    logic [KW-1:0] cand;
    logic [KW-1:0] limit;
    logic [KW-1:0] cap1;
    logic [KW-1:0] k_clip;
    logic          flat;

    assign neg      = d_reg[DW-1];
    assign mag_full = neg ? (DW'(0) - d_reg) : d_reg;
    assign mag      = mag_full[MW-1:0];
    assign cand     = k_reg | (KW'(1) << bit_reg);
    assign limit    = neg ? Z_NEG_LIMIT : Z_POS_LIMIT;
    assign cap1     = limit + KW'(1);
    assign flat     = (w_reg == '0);

    // sample store
    always_ff @(posedge clk)
    begin
        if (cmd.store && (count_reg < CW'(MAX_SAMPLES)))
        begin
            mem[count_reg[AW-1:0]] <= sample;
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.run_clr)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
            end
            else if (cmd.store && (count_reg < CW'(MAX_SAMPLES)))
            begin
                count_reg <= count_reg + CW'(1);
                sum_reg   <= sum_reg + SW'(sample);
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            d_reg <= $signed({1'b0, count_reg}) * DW'(rd_reg) - DW'(sum_reg);
        end
        // square split in halves to keep each product narrow
        if (cmd.sq)
        begin
            pp_hh_reg <= (2*L)'(mag[MW-1:H]) * (2*L)'(mag[MW-1:H]);
            pp_hl_reg <= (H+L)'(mag[MW-1:H]) * (H+L)'(mag[H-1:0]);
            pp_ll_reg <= (2*H)'(mag[H-1:0]) * (2*H)'(mag[H-1:0]);
        end
        if (cmd.sqsum)
        begin
            m2_reg <= (SQW'(pp_hh_reg) << (2*H)) + (SQW'(pp_hl_reg) << (H+1))
                    + SQW'(pp_ll_reg);
        end
        if (cmd.w_clr)
        begin
            w_reg <= '0;
        end
        else if (cmd.acc)
        begin
            w_reg <= w_reg + WW'(m2_reg);
        end
        if (cmd.rhs)
        begin
            r_reg   <= (RW'(m2_reg) * RW'(count_reg)) << FRAC_SHIFT;
            p_reg   <= '0;
            wk_reg  <= '0;
            k_reg   <= '0;
            bit_reg <= BW'(KW - 1);
        end
        // (k + 2^b)^2 w = k^2 w + 2^(b+1) k w + 2^(2b) w
        if (cmd.trial)
        begin
            trial_reg <= p_reg + (TW'(wk_reg) << ({1'b0, bit_reg} + (BW+1)'(1)))
                       + (TW'(w_reg) << {bit_reg, 1'b0});
        end
        if (cmd.decide)
        begin
            if ((cand <= cap1) && (trial_reg <= TW'(r_reg)))
            begin
                p_reg  <= trial_reg;
                wk_reg <= wk_reg + (KWW'(w_reg) << bit_reg);
                k_reg  <= cand;
            end
            bit_reg <= bit_reg - BW'(1);
        end
    end

    assign saturated   = (k_reg > limit);
    assign k_clip      = saturated ? limit : k_reg;
    assign zscore      = neg ? $signed(ZW'(0) - ZW'(k_clip)) : $signed(ZW'(k_clip));
    assign flat_column = flat;

    assign status.last_idx = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign status.skip     = flat || (d_reg == '0);
    assign status.bit_zero = (bit_reg == '0);

endmodule

[rtl/zsn_ctrl.sv]
// sequencer for loading, statistics pass and per-sample search
`timescale 1ns / 1ps
module zsn_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 final_sample,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output zsn_pkg::zsn_cmd_t    cmd,
    input  zsn_pkg::zsn_status_t status
);
    import zsn_pkg::*;

    zsn_state_t state_reg, state_next;
    logic       pass2_reg, pass2_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            pass2_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass2_reg <= pass2_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pass2_next = pass2_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (final_sample)
                    begin
                        cmd.w_clr   = 1'b1;
                        cmd.idx_clr = 1'b1;
                        pass2_next  = 1'b0;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = ST_SQSUM;
            end
            ST_SQSUM:
            begin
                cmd.sqsum  = 1'b1;
                state_next = pass2_reg ? ST_RHS : ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_READ;
                if (status.last_idx)
                begin
                    cmd.idx_clr = 1'b1;
                    pass2_next  = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_RHS:
            begin
                cmd.rhs    = 1'b1;
                state_next = status.skip ? ST_OUT : ST_TRIAL;
            end
            ST_TRIAL:
            begin
                cmd.trial  = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.bit_zero ? ST_OUT : ST_TRIAL;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.last_idx)
                    begin
                        cmd.run_clr = 1'b1;
                        state_next  = ST_LOAD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

[tb/sv/tb_zscore_normalizer_core.sv]
// self-checking testbench of the z-score normaliser core
`timescale 1ns / 1ps
module tb_zscore_normalizer_core;
    import zsn_pkg::*;

    localparam int NMAX      = DEF_MAX_SAMPLES;
    localparam int CYC_LIMIT = 3000000;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
        logic               drain;
    } sample_beat_t;

    typedef struct {
        logic signed [15:0] zscore;
        logic               flat;
        logic               sat;
        logic               last;
    } zbeat_t;

    logic clk;
    logic rst_n;
    zsn_in_if  #(.SAMPLE_BITS(DEF_SAMPLE_BITS)) samples ();
    zsn_out_if results ();

    zscore_normalizer_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples.sink),
        .results (results.source)
    );

    sample_beat_t pending_q[$];
    zbeat_t       zscore_q[$];
    int           errors;
    int           cycles;

    // handshakes seen at the last rising edge
    logic         in_taken;
    logic         out_taken;

    // predictor state
    logic signed [15:0] col_store[NMAX];
    int                 col_count;
    longint             col_sum;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    task automatic predict_beat(input logic signed [15:0] x, input logic last);
        logic [127:0] w;
        logic [127:0] mag;
        logic [127:0] rhs;
        longint       d;
        longint       n;
        logic [16:0]  lo;
        logic [16:0]  hi;
        logic [16:0]  mid;
        logic [16:0]  lim;
        zbeat_t       e;
        if (col_count < NMAX)
        begin
            col_store[col_count] = x;
            col_count++;
            col_sum += x;
        end
        if (last)
        begin
            n = col_count;
            w = '0;
            for (int i = 0; i < col_count; i++)
            begin
                d   = n * col_store[i] - col_sum;
                mag = (d < 0) ? -d : d;
                w   = w + mag * mag;
            end
            for (int i = 0; i < col_count; i++)
            begin
                d   = n * col_store[i] - col_sum;
                mag = (d < 0) ? -d : d;
                e.flat = (w == 0);
                e.sat  = 1'b0;
                e.zscore = '0;
                e.last = (i == col_count - 1);
                if (w != 0 && mag != 0)
                begin
                    rhs = (mag * mag * n) << 20;
                    lim = (d < 0) ? 17'd32768 : 17'd32767;
                    lo  = '0;
                    hi  = lim + 17'd1;
                    while (lo < hi)
                    begin
                        mid = (lo + hi + 17'd1) / 17'd2;
                        if (w * mid * mid <= rhs)
                            lo = mid;
                        else
                            hi = mid - 17'd1;
                    end
                    if (lo > lim)
                    begin
                        lo    = lim;
                        e.sat = 1'b1;
                    end
                    e.zscore = (d < 0) ? -lo[15:0] : lo[15:0];
                end
                zscore_q = {zscore_q, e};
            end
            col_count = 0;
            col_sum   = 0;
        end
    endtask

    // sender: one beat a time, random gaps, optional drain before a beat
    int           in_gap;
    sample_beat_t cur;
    always @(negedge clk)
    begin
        if (rst_n && (!samples.valid || in_taken))
        begin
            if (samples.valid)
                in_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
            if (in_gap > 0)
            begin
                in_gap--;
                samples.valid <= 1'b0;
            end
            else if (pending_q.size() > 0 && !(pending_q[0].drain && zscore_q.size() > 0))
            begin
                cur = pending_q.pop_front();
                samples.sample       <= cur.sample;
                samples.final_sample <= cur.last;
                samples.valid        <= 1'b1;
            end
            else
                samples.valid <= 1'b0;
        end
    end

    // receiver: random stall per beat, with stall-free stretches
    int   out_gap;
    logic out_burst;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                if ($urandom_range(0, 15) == 0)
                    out_burst = ~out_burst;
                out_gap = out_burst ? 0 : $urandom_range(0, 18);
            end
            if (out_gap > 0)
            begin
                out_gap--;
                results.ready <= 1'b0;
            end
            else
                results.ready <= 1'b1;
        end
    end

    // monitor
    zbeat_t exp_b;
    always @(posedge clk)
    begin
        in_taken  = rst_n && samples.valid && samples.ready;
        out_taken = rst_n && results.valid && results.ready;
        if (rst_n)
        begin
            if (samples.valid && samples.ready)
                predict_beat(samples.sample, samples.final_sample);
            if (results.valid && results.ready)
            begin
                if (zscore_q.size() == 0)
                    report("result beat with nothing expected");
                else
                begin
                    exp_b = zscore_q.pop_front();
                    if (results.zscore !== exp_b.zscore)
                        report($sformatf("zscore %0d, want %0d", results.zscore, exp_b.zscore));
                    if (results.flat_column !== exp_b.flat)
                        report($sformatf("flat_column %b, want %b",
                                         results.flat_column, exp_b.flat));
                    if (results.saturated !== exp_b.sat)
                        report($sformatf("saturated %b, want %b", results.saturated, exp_b.sat));
                    if (results.final_result !== exp_b.last)
                        report($sformatf("final_result %b, want %b",
                                         results.final_result, exp_b.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYC_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_beat(input logic signed [15:0] x, input logic last, input logic drain);
        sample_beat_t b;
        b.sample = x;
        b.last   = last;
        b.drain  = drain;
        pending_q = {pending_q, b};
    endtask

    task automatic add_column(input int len, input int spread, input logic drain);
        int base;
        base = $urandom_range(0, 65535) - 32768;
        for (int i = 0; i < len; i++)
        begin
            if (spread == 0)
                add_beat(16'($urandom()), i == len - 1, drain && i == 0);
            else
                add_beat(16'(base + $urandom_range(0, spread) - spread / 2),
                         i == len - 1, drain && i == 0);
        end
    endtask

    initial
    begin
        int total;
        int len;
        errors = 0;
        cycles = 0;
        col_count = 0;
        col_sum = 0;
        in_gap = 0;
        out_gap = 0;
        out_burst = 1'b0;
        in_taken = 1'b0;
        out_taken = 1'b0;
        samples.valid = 1'b0;
        samples.sample = '0;
        samples.final_sample = 1'b0;
        results.ready = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes
        add_beat(-16'sd32768, 1'b0, 1'b0);
        add_beat(16'sd32767, 1'b1, 1'b0);
        // single sample, flat
        add_beat(16'sd1234, 1'b1, 1'b0);
        // constant column, flat
        add_beat(-16'sd7, 1'b0, 1'b0);
        add_beat(-16'sd7, 1'b0, 1'b0);
        add_beat(-16'sd7, 1'b1, 1'b0);
        // middle sample equals the mean
        add_beat(-16'sd5, 1'b0, 1'b1);
        add_beat(16'sd0, 1'b0, 1'b0);
        add_beat(16'sd5, 1'b1, 1'b0);
        // one outlier among equal samples
        add_beat(16'sd0, 1'b0, 1'b0);
        add_beat(16'sd0, 1'b0, 1'b0);
        add_beat(16'sd0, 1'b0, 1'b0);
        add_beat(16'sd32767, 1'b1, 1'b0);
        // store full: excess samples dropped, final mark kept
        add_column(70, 0, 1'b1);

        // the directed beats above count towards the total
        total = pending_q.size();
        while (total < 320)
        begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
            add_column(len, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40) : 0,
                       $urandom_range(0, 9) == 0);
            total += len;
        end

        while (pending_q.size() > 0 || samples.valid || zscore_q.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0 && zscore_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
